// ----- sv/bpa_pkg.sv -----
package bpa_pkg;

    // map word geometry
    localparam int WORD_BITS = 64;
    localparam int OFF_W     = 6;
    localparam logic [WORD_BITS-1:0] WORD_ONES = {WORD_BITS{1'b1}};

    // field widths
    localparam int ADDR_W   = 48;
    localparam int BYTES_W  = 32;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    // configuration
    localparam logic [ADDR_W-1:0] HEAP_BASE_RESET = 48'h0000_0020_0000;
    localparam logic              REG_HEAP_BASE   = 1'b0;

    // request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_NOMEM   = 2'd2
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MARK_RD,
        S_MARK,
        S_FREE_RD,
        S_FREE_WR,
        S_DONE
    } state_t;

endpackage

// ----- sv/bpa_map_ram.sv -----
module bpa_map_ram
    import bpa_pkg::*;
#(
    parameter int DEPTH = 512,
    parameter int AW    = 9
)
(
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output logic [WORD_BITS-1:0] rd_data,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [WORD_BITS-1:0] wr_data
);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds its word between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/bpa_find_unit.sv -----
module bpa_find_unit
    import bpa_pkg::*;
(
    input  logic [WORD_BITS-1:0] vec,
    input  logic [OFF_W-1:0]     start,
    output logic                 found,
    output logic [OFF_W-1:0]     idx
);

    logic [WORD_BITS-1:0] masked;

    // lowest set bit at or above the start offset
    always_comb
    begin
        masked = vec & (WORD_ONES << start);
        found  = |masked;
        idx    = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (masked[i])
            begin
                idx = OFF_W'(i);
            end
        end
    end

endmodule

// ----- sv/bitmap_page_allocator.sv -----
// First-fit page allocator over a used map of 64-bit words in one single-port-read memory.
// Allocate: scans the map words in order through the shared first-bit unit, seeking a free
//   bit and then a used bit until a free run is long enough, then marks each word of the run.
// Free: read and write back one map word. Clear: zero every map word. One item at a time, result registered.
// Reset: asynchronous active low; a clearing pass over all MAP_WORDS words (512 by default)
//   zeroes the map while s_tready stays low; configuration writes are taken throughout.
module bitmap_page_allocator
    import bpa_pkg::*;
#(
    parameter int PAGE_COUNT = 32768,
    parameter int PAGE_BYTES = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,

    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // request_bytes [31:0], free_address [79:32]
    input  logic [1:0]  s_tuser,   // kind [1:0]

    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // status [1:0], alloc_address [49:2], zero [55:50]

    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int MAP_WORDS  = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int IDX_W      = WORD_AW + OFF_W;
    localparam int LEN_W      = IDX_W + 1;
    localparam int TAIL_BITS  = PAGE_COUNT % WORD_BITS;
    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(MAP_WORDS - 1);
    localparam logic [WORD_BITS-1:0] TAIL_PAD =
        (TAIL_BITS == 0) ? '0 : ~((64'd1 << TAIL_BITS) - 64'd1);

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    heap_base_reg;
    logic [LEN_W-1:0]     pages_reg, pages_next;
    logic [WORD_AW-1:0]   pos_word_reg, pos_word_next;
    logic [OFF_W-1:0]     pos_off_reg, pos_off_next;
    logic                 seek_used_reg, seek_used_next;
    logic [IDX_W-1:0]     run_start_reg, run_start_next;
    logic [IDX_W-1:0]     run_end_reg, run_end_next;
    logic [WORD_AW-1:0]   mark_word_reg, mark_word_next;
    logic [WORD_AW-1:0]   free_word_reg, free_word_next;
    logic [OFF_W-1:0]     free_off_reg, free_off_next;
    logic [WORD_AW-1:0]   clr_word_reg, clr_word_next;
    logic                 clr_resp_reg, clr_resp_next;
    status_t              res_status_reg, res_status_next;
    logic [ADDR_W-1:0]    res_addr_reg, res_addr_next;
    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg, out_status_next;
    logic [ADDR_W-1:0]    out_addr_reg, out_addr_next;

    // map memory and shared search unit
    logic                 rd_en, wr_en;
    logic [WORD_AW-1:0]   rd_addr, wr_addr;
    logic [WORD_BITS-1:0] rd_data, wr_data;
    logic [WORD_BITS-1:0] eff_word, find_vec;
    logic                 find_found;
    logic [OFF_W-1:0]     find_idx;

    // request decode
    logic [BYTES_W-1:0]   req_bytes;
    logic [ADDR_W-1:0]    req_faddr;
    logic [BYTES_W:0]     req_pages;
    logic [ADDR_W-1:0]    free_diff, free_page;
    logic                 free_ok;

    // scan arithmetic
    logic [IDX_W-1:0]     cur_idx;
    logic [LEN_W-1:0]     len_found, len_end, word_end;
    logic [ADDR_W-1:0]    run_addr;
    logic [IDX_W-1:0]     run_last;
    logic [OFF_W-1:0]     mark_lo, mark_hi;
    logic [WORD_BITS-1:0] mark_mask;

    bpa_map_ram #(
        .DEPTH (MAP_WORDS),
        .AW    (WORD_AW)
    ) u_map (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // pages past the end read as used
    assign eff_word = rd_data | ((pos_word_reg == LAST_WORD) ? TAIL_PAD : '0);
    assign find_vec = seek_used_reg ? eff_word : ~eff_word;

    bpa_find_unit u_find (
        .vec   (find_vec),
        .start (pos_off_reg),
        .found (find_found),
        .idx   (find_idx)
    );

    // request fields and their checks
    assign req_bytes = s_tdata[31:0];
    assign req_faddr = s_tdata[79:32];
    assign req_pages = ({1'b0, req_bytes} + (BYTES_W + 1)'(PAGE_BYTES - 1)) >> PAGE_SHIFT;
    assign free_diff = req_faddr - heap_base_reg;
    assign free_page = free_diff >> PAGE_SHIFT;
    assign free_ok   = (req_faddr >= heap_base_reg) && (free_page < ADDR_W'(PAGE_COUNT));

    // run lengths seen by the scan
    assign cur_idx   = {pos_word_reg, find_idx};
    assign word_end  = LEN_W'({pos_word_reg, {OFF_W{1'b0}}}) + LEN_W'(WORD_BITS);
    assign len_found = LEN_W'(cur_idx) - LEN_W'(run_start_reg);
    assign len_end   = word_end - LEN_W'(run_start_reg);
    assign run_addr  = heap_base_reg + (ADDR_W'(run_start_reg) << PAGE_SHIFT);
    assign run_last  = IDX_W'(LEN_W'(run_start_reg) + pages_reg - LEN_W'(1));

    // bits of the current word that the run covers
    assign mark_lo   = (mark_word_reg == run_start_reg[IDX_W-1:OFF_W]) ?
                       run_start_reg[OFF_W-1:0] : '0;
    assign mark_hi   = (mark_word_reg == run_end_reg[IDX_W-1:OFF_W]) ?
                       run_end_reg[OFF_W-1:0] : OFF_W'(WORD_BITS - 1);
    assign mark_mask = (WORD_ONES << mark_lo) &
                       (WORD_ONES >> (OFF_W'(WORD_BITS - 1) - mark_hi));

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_word_reg   <= '0;
            clr_resp_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_word_reg   <= clr_word_next;
            clr_resp_reg   <= clr_resp_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        pages_reg      <= pages_next;
        pos_word_reg   <= pos_word_next;
        pos_off_reg    <= pos_off_next;
        seek_used_reg  <= seek_used_next;
        run_start_reg  <= run_start_next;
        run_end_reg    <= run_end_next;
        mark_word_reg  <= mark_word_next;
        free_word_reg  <= free_word_next;
        free_off_reg   <= free_off_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
    end

    // heap base register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg <= HEAP_BASE_RESET;
        end
        else if (psel && penable && pwrite && (paddr[3] == REG_HEAP_BASE))
        begin
            heap_base_reg <= pwdata[ADDR_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[3] == REG_HEAP_BASE) ? {16'd0, heap_base_reg} : '0;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        pages_next      = pages_reg;
        pos_word_next   = pos_word_reg;
        pos_off_next    = pos_off_reg;
        seek_used_next  = seek_used_reg;
        run_start_next  = run_start_reg;
        run_end_next    = run_end_reg;
        mark_word_next  = mark_word_reg;
        free_word_next  = free_word_reg;
        free_off_next   = free_off_reg;
        clr_word_next   = clr_word_reg;
        clr_resp_next   = clr_resp_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_word_reg;
                wr_data = '0;
                if (clr_word_reg == LAST_WORD)
                begin
                    state_next      = clr_resp_reg ? S_DONE : S_IDLE;
                    res_status_next = ST_OK;
                    res_addr_next   = '0;
                end
                else
                begin
                    clr_word_next = clr_word_reg + WORD_AW'(1);
                end
            end

            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    res_addr_next = '0;
                    case (kind_t'(s_tuser))
                        KIND_ALLOC:
                        begin
                            if (req_bytes == '0)
                            begin
                                res_status_next = ST_INVALID;
                                state_next      = S_DONE;
                            end
                            else if (req_pages > (BYTES_W + 1)'(PAGE_COUNT))
                            begin
                                res_status_next = ST_NOMEM;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                pages_next     = req_pages[LEN_W-1:0];
                                pos_word_next  = '0;
                                pos_off_next   = '0;
                                seek_used_next = 1'b0;
                                rd_en          = 1'b1;
                                rd_addr        = '0;
                                state_next     = S_SCAN;
                            end
                        end
                        KIND_FREE:
                        begin
                            if (free_ok)
                            begin
                                free_word_next = free_page[IDX_W-1:OFF_W];
                                free_off_next  = free_page[OFF_W-1:0];
                                state_next     = S_FREE_RD;
                            end
                            else
                            begin
                                res_status_next = ST_INVALID;
                                state_next      = S_DONE;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            clr_word_next = '0;
                            clr_resp_next = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        default:
                        begin
                            res_status_next = ST_INVALID;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (!seek_used_reg)
                begin
                    // looking for the start of a free run
                    if (find_found)
                    begin
                        run_start_next = cur_idx;
                        pos_off_next   = find_idx;
                        seek_used_next = 1'b1;
                    end
                    else if (pos_word_reg == LAST_WORD)
                    begin
                        res_status_next = ST_NOMEM;
                        res_addr_next   = '0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        pos_word_next = pos_word_reg + WORD_AW'(1);
                        pos_off_next  = '0;
                        rd_en         = 1'b1;
                        rd_addr       = pos_word_reg + WORD_AW'(1);
                    end
                end
                else
                begin
                    // looking for the end of the current free run
                    if ((find_found && (len_found >= pages_reg)) ||
                        (!find_found && (len_end >= pages_reg)))
                    begin
                        res_status_next = ST_OK;
                        res_addr_next   = run_addr;
                        run_end_next    = run_last;
                        state_next      = S_MARK_RD;
                    end
                    else if (find_found)
                    begin
                        pos_off_next   = find_idx;
                        seek_used_next = 1'b0;
                    end
                    else if (pos_word_reg == LAST_WORD)
                    begin
                        res_status_next = ST_NOMEM;
                        res_addr_next   = '0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        pos_word_next = pos_word_reg + WORD_AW'(1);
                        pos_off_next  = '0;
                        rd_en         = 1'b1;
                        rd_addr       = pos_word_reg + WORD_AW'(1);
                    end
                end
            end

            S_MARK_RD:
            begin
                rd_en          = 1'b1;
                rd_addr        = run_start_reg[IDX_W-1:OFF_W];
                mark_word_next = run_start_reg[IDX_W-1:OFF_W];
                state_next     = S_MARK;
            end

            S_MARK:
            begin
                wr_en   = 1'b1;
                wr_addr = mark_word_reg;
                wr_data = rd_data | mark_mask;
                if (mark_word_reg == run_end_reg[IDX_W-1:OFF_W])
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en          = 1'b1;
                    rd_addr        = mark_word_reg + WORD_AW'(1);
                    mark_word_next = mark_word_reg + WORD_AW'(1);
                end
            end

            S_FREE_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = free_word_reg;
                state_next = S_FREE_WR;
            end

            S_FREE_WR:
            begin
                wr_en           = 1'b1;
                wr_addr         = free_word_reg;
                wr_data         = rd_data & ~(64'd1 << free_off_reg);
                res_status_next = ST_OK;
                res_addr_next   = '0;
                state_next      = S_DONE;
            end

            S_DONE:
            begin
                // hand the result to the output register once it is free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_addr_next   = res_addr_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_addr_reg, out_status_reg};

endmodule

// ----- sv/bpa_checker.sv -----
module bpa_checker
    import bpa_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // only a successful allocate carries an address
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] != ST_OK) |-> (m_tdata[49:2] == '0))
        else $error("address on a failed request");

    // status is a defined code and padding stays zero
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] != 2'd3) && (m_tdata[55:50] == '0))
        else $error("bad status or padding");

    // one item at a time: busy right after an item is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item taken while busy");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- test/bitmap_page_allocator_tb.sv -----
module bitmap_page_allocator_tb
    import bpa_pkg::*;
();

    localparam int MAP_PAGES = 32768;
    localparam int PAGE_SPAN = 4096;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam int PHASE_ITEMS    = 78;
    localparam int HOLDOFF_CYCLES = 3000;
    localparam int SETTLE_CYCLES  = 600;
    localparam int CYCLE_LIMIT    = 3000000;
    localparam logic [3:0] HEAP_BASE_ADDR = 4'd8 * REG_HEAP_BASE;
    localparam logic [3:0] UNMAPPED_ADDR  = 4'd8;

    // tracks the used map and the results owed by the allocator
    class page_allocation_tracker;
        logic [ADDR_W-1:0]   heap_base;
        bit [MAP_PAGES-1:0]  page_used;
        logic [STATUS_W-1:0] due_status[$];
        logic [ADDR_W-1:0]   due_address[$];
        logic [ADDR_W-1:0]   run_base[$];
        int                  run_length[$];
        int errors, replies, requests, placed, no_room, rejected, frees, clears;

        function new();
            heap_base = HEAP_BASE_RESET;
            page_used = '0;
            errors    = 0;
            replies   = 0;
            requests  = 0;
            placed    = 0;
            no_room   = 0;
            rejected  = 0;
            frees     = 0;
            clears    = 0;
        endfunction

        function void forget_runs();
            run_base.delete();
            run_length.delete();
        endfunction

        // first fit: lowest run of free pages long enough, marked used on success
        function void place_run(input logic [BYTES_W-1:0] nbytes,
                                output logic [STATUS_W-1:0] st,
                                output logic [ADDR_W-1:0] addr);
            logic [63:0]       want;
            logic [ADDR_W-1:0] first_page;
            int                idx;
            int                run_len;
            int                run_begin;
            bit                found;
            st        = ST_NOMEM;
            addr      = '0;
            found     = 1'b0;
            idx       = 0;
            run_len   = 0;
            run_begin = 0;
            want      = ({32'd0, nbytes} + 64'd4095) / 64'd4096;
            if (nbytes == '0)
                st = ST_INVALID;
            else if (want <= MAP_PAGES)
            begin
                while (!found && idx < MAP_PAGES)
                begin
                    if (page_used[idx])
                        run_len = 0;
                    else
                    begin
                        if (run_len == 0)
                            run_begin = idx;
                        run_len++;
                        found = (run_len == want);
                    end
                    idx++;
                end
                if (found)
                begin
                    for (int j = run_begin; j < run_begin + run_len; j++)
                        page_used[j] = 1'b1;
                    first_page = ADDR_W'(run_begin);
                    st   = ST_OK;
                    addr = heap_base + first_page * PAGE_SPAN;
                    run_base.push_back(addr);
                    run_length.push_back(run_len);
                    if (run_base.size() > 64)
                    begin
                        void'(run_base.pop_front());
                        void'(run_length.pop_front());
                    end
                end
            end
        endfunction

        // release the single page holding the address
        function void release_page(input logic [ADDR_W-1:0] faddr,
                                   output logic [STATUS_W-1:0] st);
            logic [ADDR_W-1:0] page;
            st = ST_INVALID;
            if (faddr >= heap_base)
            begin
                page = (faddr - heap_base) / PAGE_SPAN;
                if (page < MAP_PAGES)
                begin
                    page_used[page] = 1'b0;
                    st = ST_OK;
                end
            end
        endfunction

        function void note_request(input logic [KIND_W-1:0] kind,
                                   input logic [BYTES_W-1:0] nbytes,
                                   input logic [ADDR_W-1:0] faddr);
            logic [STATUS_W-1:0] st;
            logic [ADDR_W-1:0]   addr;
            st   = ST_INVALID;
            addr = '0;
            requests++;
            case (kind)
                KIND_ALLOC: place_run(nbytes, st, addr);
                KIND_FREE:
                begin
                    release_page(faddr, st);
                    frees++;
                end
                KIND_CLEAR:
                begin
                    page_used = '0;
                    forget_runs();
                    st = ST_OK;
                    clears++;
                end
                default: st = ST_INVALID;
            endcase
            if (kind == KIND_ALLOC)
            begin
                if (st == ST_OK)
                    placed++;
                else if (st == ST_NOMEM)
                    no_room++;
            end
            if (st == ST_INVALID)
                rejected++;
            due_status.push_back(st);
            due_address.push_back(addr);
        endfunction

        function void check_reply(input logic [55:0] beat);
            logic [STATUS_W-1:0] st;
            logic [ADDR_W-1:0]   addr;
            replies++;
            if (due_status.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, status %0d address %h", $time,
                         beat[1:0], beat[49:2]);
            end
            else
            begin
                st   = due_status.pop_front();
                addr = due_address.pop_front();
                if (beat[1:0] != st)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time, st, beat[1:0]);
                end
                if (beat[49:2] != addr)
                begin
                    errors++;
                    $display("%0t: address expected %h actual %h", $time, addr, beat[49:2]);
                end
                if (beat[55:50] != '0)
                begin
                    errors++;
                    $display("%0t: padding expected 0 actual %h", $time, beat[55:50]);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;   // request_bytes [31:0], free_address [79:32]
    logic [1:0]  s_tuser;   // kind [1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // status [1:0], alloc_address [49:2], zero [55:50]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    page_allocation_tracker tracker;

    bitmap_page_allocator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[bitmap_page_allocator] ERROR");
        $finish;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_reply(m_tdata);
    end

    // result side back-pressure, with one long hold-off
    initial
    begin
        int stall;
        bit steady;
        bit held;
        stall    = 0;
        steady   = 1'b0;
        held     = 1'b0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && tracker.replies >= 60)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(negedge clk);
            end
            else if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                if ($urandom_range(0, 99) < 3)
                    steady = !steady;
                if (steady)
                    m_tready <= 1'b1;
                else if ($urandom_range(0, 99) < 4)
                begin
                    stall = $urandom_range(10, 60);
                    m_tready <= 1'b0;
                end
                else
                    m_tready <= ($urandom_range(0, 99) < 65);
            end
        end
    end

    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic [BYTES_W-1:0] nbytes,
                                input logic [ADDR_W-1:0] faddr);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {faddr, nbytes};
        do
            @(posedge clk);
        while (!s_tready);
        tracker.note_request(kind, nbytes, faddr);
    endtask

    task automatic hold_requests(input int cycles);
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic drain_replies();
        hold_requests(1);
        while (tracker.due_status.size() != 0)
            @(posedge clk);
    endtask

    task automatic request_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r >= 40 && r < 92)
            hold_requests($urandom_range(1, 4));
        else if (r >= 92)
            hold_requests($urandom_range(10, 60));
    endtask

    task automatic apb_transfer(input logic write, input logic [3:0] addr,
                                input logic [63:0] wdata, output logic [63:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // mostly allocations and frees of live runs, some clears and malformed requests
    task automatic pick_request(output logic [KIND_W-1:0] kind,
                                output logic [BYTES_W-1:0] nbytes,
                                output logic [ADDR_W-1:0] faddr);
        int r;
        int s;
        int k;
        r      = $urandom_range(0, 99);
        s      = $urandom_range(0, 99);
        nbytes = $urandom;
        faddr  = ADDR_W'({$urandom, $urandom});
        kind   = KIND_ALLOC;
        if (r < 48)
        begin
            if (s < 70)
                nbytes = $urandom_range(1, 4 * PAGE_SPAN);
            else if (s < 88)
                nbytes = $urandom_range(1, 64 * PAGE_SPAN);
            else if (s < 92)
                nbytes = $urandom_range(1000 * PAGE_SPAN, 20000 * PAGE_SPAN);
            else if (s < 97)
                nbytes = $urandom;
            else
                nbytes = '0;
        end
        else if (r < 90)
        begin
            kind = KIND_FREE;
            if (s < 75 && tracker.run_base.size() != 0)
            begin
                k     = $urandom_range(0, tracker.run_base.size() - 1);
                faddr = tracker.run_base[k]
                        + $urandom_range(0, tracker.run_length[k] - 1) * PAGE_SPAN
                        + $urandom_range(0, PAGE_SPAN - 1);
            end
            else if (s < 85)
                faddr = tracker.heap_base - $urandom_range(1, 1 << 20);
            else if (s < 93)
                faddr = tracker.heap_base + 48'h800_0000 + $urandom_range(0, 1 << 24);
        end
        else if (r < 97)
            kind = KIND_CLEAR;
        else
            kind = KIND_UNUSED;
    endtask

    initial
    begin
        logic [63:0]         rdata;
        logic [ADDR_W-1:0]   bases [5];
        logic [KIND_W-1:0]   kind;
        logic [BYTES_W-1:0]  nbytes;
        logic [ADDR_W-1:0]   faddr;
        tracker  = new();
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // heap base comes up at its reset value
        apb_transfer(1'b0, HEAP_BASE_ADDR, '0, rdata);
        if (rdata != {16'd0, HEAP_BASE_RESET})
        begin
            tracker.errors++;
            $display("%0t: heap base expected %h actual %h", $time,
                     {16'd0, HEAP_BASE_RESET}, rdata);
        end

        // directed corners at the reset heap base
        send_request(KIND_ALLOC, 32'd1, '0);
        send_request(KIND_ALLOC, 32'd4096, '0);
        send_request(KIND_ALLOC, 32'd4097, '0);
        send_request(KIND_ALLOC, 32'd0, '0);
        send_request(KIND_FREE, '0, HEAP_BASE_RESET + 48'd4101);
        send_request(KIND_FREE, '0, HEAP_BASE_RESET + 48'd4096);
        send_request(KIND_ALLOC, 32'd4096, '0);
        send_request(KIND_FREE, '0, HEAP_BASE_RESET - 48'd1);
        send_request(KIND_FREE, '0, HEAP_BASE_RESET + 48'h800_0000);
        send_request(KIND_FREE, '0, HEAP_BASE_RESET + 48'h7FF_FFFF);
        send_request(KIND_UNUSED, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_request(KIND_ALLOC, 32'hFFFF_FFFF, '0);
        send_request(KIND_ALLOC, 32'h0800_1000, '0);
        send_request(KIND_CLEAR, '0, '0);
        send_request(KIND_ALLOC, 32'h0800_0000, '0);
        send_request(KIND_ALLOC, 32'd1, '0);
        send_request(KIND_FREE, '0, 48'hFFFF_FFFF_FFFF);
        send_request(KIND_FREE, '0, '0);
        send_request(KIND_CLEAR, '0, '0);

        // random phases over several heap bases, the extremes among them
        bases[0] = '0;
        bases[1] = {16'($urandom_range(0, 65535)), 32'($urandom)};
        bases[2] = 48'hFFFF_FFFF_FFFF;
        bases[3] = 48'hFFFF_FFFF_8000;
        bases[4] = HEAP_BASE_RESET;
        for (int p = 0; p < 5; p++)
        begin
            drain_replies();
            apb_transfer(1'b1, HEAP_BASE_ADDR, {16'd0, bases[p]}, rdata);
            apb_transfer(1'b1, UNMAPPED_ADDR, {$urandom, $urandom}, rdata);
            apb_transfer(1'b0, HEAP_BASE_ADDR, '0, rdata);
            tracker.heap_base = bases[p];
            tracker.forget_runs();
            if (rdata != {16'd0, bases[p]})
            begin
                tracker.errors++;
                $display("%0t: heap base expected %h actual %h", $time,
                         {16'd0, bases[p]}, rdata);
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick_request(kind, nbytes, faddr);
                send_request(kind, nbytes, faddr);
                if ($urandom_range(0, 99) == 0)
                    drain_replies();
                else if (n >= 12)
                    request_gap();
            end
        end

        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d requests over 6 heap bases: %0d runs placed, %0d out of memory",
                 tracker.requests, tracker.placed, tracker.no_room);
        $display("%0d frees, %0d clears, %0d rejected as invalid",
                 tracker.frees, tracker.clears, tracker.rejected);
        if (tracker.errors == 0)
            $display("[bitmap_page_allocator] OK");
        else
            $display("[bitmap_page_allocator] ERROR");
        $finish;
    end

endmodule
